[rtl/core/sn2_pkg.sv]
// ----------------------------------------------------------------------------
// sn2_pkg: shared types and constants for the 2-D simplex noise core
// Holds the pipeline depth, hash, gradient, falloff and scale constants, and
// the stage enable group that the top level hands to each corner slice.
// ----------------------------------------------------------------------------
package sn2_pkg;

    // Register stages from input to output register
    localparam int NUM_STAGES = 7;

    // Polynomial byte hash h = (A*x+B)*x, twice with other constants; first adds y
    localparam logic [7:0] HASH_A1 = 8'd13;
    localparam logic [7:0] HASH_B1 = 8'd3;
    localparam logic [7:0] HASH_A2 = 8'd17;
    localparam logic [7:0] HASH_B2 = 8'd7;

    // Gradient component magnitudes
    localparam logic signed [7:0] GRAD_MAJ = 8'sd127;
    localparam logic signed [7:0] GRAD_MIN = 8'sd64;

    // Falloff: zero beyond R_LIMIT, otherwise (FALL_BASE - 2.5r)^4
    localparam logic [7:0] R_LIMIT   = 8'd102;
    localparam logic [7:0] FALL_BASE = 8'd255;

    // Output scale, applied as SCALE/128
    localparam logic signed [8:0] OUT_SCALE = 9'sd136;

    // Per-stage load enables of one corner slice
    typedef struct packed {
        logic hash_en;   // first hash round, squared radius
        logic mix_en;    // second hash round, falloff base
        logic grad_en;   // gradient ramp, first falloff square
        logic fall_en;   // second falloff square
        logic prod_en;   // ramp times falloff
    } corner_en_t;

endpackage

[rtl/core/sn2_corner.sv]
// ----------------------------------------------------------------------------
// sn2_corner: contribution of one simplex corner
// Five register stages: hash, gradient select, ramp and quartic falloff,
// then their product. Each stage loads only when its enable is high.
// ----------------------------------------------------------------------------
module sn2_corner (
    input  logic                   aclk,
    input  sn2_pkg::corner_en_t    en,
    input  logic [7:0]             xc,    // corner x index (byte)
    input  logic [7:0]             vc,    // corner y index (byte)
    input  logic signed [7:0]      xf,    // x offset, 1.7
    input  logic signed [7:0]      yf,    // y offset, 1.7
    output logic signed [7:0]      n      // contribution, 1.7
);

    // Stage A: first hash round and squared radius
    logic [7:0]         hp_reg, hp_next;
    logic [7:0]         r_reg, r_next;
    logic signed [7:0]  xf_a_reg, yf_a_reg;
    logic signed [15:0] sqx, sqy;
    logic [8:0]         r_sum;

    // Stage B: second hash round and falloff base
    logic [7:0]         h_reg, h_next;
    logic [7:0]         m0_reg, m0_next;
    logic signed [7:0]  xf_b_reg, yf_b_reg;

    // Stage C: gradient ramp and first square
    logic signed [7:0]  gx_mag, gy_mag, gx, gy;
    logic signed [15:0] px, py;
    logic signed [7:0]  g_reg, g_next;
    logic [15:0]        m0_sq;
    logic [7:0]         m1_reg;

    // Stage D: second square
    logic [15:0]        m1_sq;
    logic [7:0]         m2_reg;
    logic signed [7:0]  g_d_reg;

    // Stage E: ramp times falloff
    logic signed [16:0] gm;
    logic signed [7:0]  n_reg;

    always_comb begin
        hp_next = (sn2_pkg::HASH_A1 * xc + sn2_pkg::HASH_B1) * xc + vc;
        sqx     = xf * xf;
        sqy     = yf * yf;
        r_sum   = {1'b0, sqx[14:7]} + {1'b0, sqy[14:7]};
        r_next  = r_sum[7:0];
    end

    always_ff @(posedge aclk) begin
        if (en.hash_en) begin
            hp_reg   <= hp_next;
            r_reg    <= r_next;
            xf_a_reg <= xf;
            yf_a_reg <= yf;
        end
    end

    always_comb begin
        h_next = (sn2_pkg::HASH_A2 * hp_reg + sn2_pkg::HASH_B2) * hp_reg;
        if (r_reg > sn2_pkg::R_LIMIT) begin
            m0_next = 8'd0;
        end else begin
            m0_next = sn2_pkg::FALL_BASE - {r_reg[6:0], 1'b0} - {1'b0, r_reg[7:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en.mix_en) begin
            h_reg    <= h_next;
            m0_reg   <= m0_next;
            xf_b_reg <= xf_a_reg;
            yf_b_reg <= yf_a_reg;
        end
    end

    // Hash bit 1 swaps the component magnitudes, bits 3 and 2 flip signs
    always_comb begin
        gx_mag = h_reg[1] ? sn2_pkg::GRAD_MIN : sn2_pkg::GRAD_MAJ;
        gy_mag = h_reg[1] ? sn2_pkg::GRAD_MAJ : sn2_pkg::GRAD_MIN;
        gx     = h_reg[3] ? -gx_mag : gx_mag;
        gy     = h_reg[2] ? -gy_mag : gy_mag;
        px     = gx * xf_b_reg;
        py     = gy * yf_b_reg;
        // low byte of the sum depends only on the low bytes of each term
        g_next = px[14:7] + py[14:7];
        m0_sq  = m0_reg * m0_reg;
    end

    always_ff @(posedge aclk) begin
        if (en.grad_en) begin
            g_reg  <= g_next;
            m1_reg <= m0_sq[15:8];
        end
    end

    assign m1_sq = m1_reg * m1_reg;

    always_ff @(posedge aclk) begin
        if (en.fall_en) begin
            m2_reg  <= m1_sq[15:8];
            g_d_reg <= g_reg;
        end
    end

    assign gm = g_d_reg * $signed({1'b0, m2_reg});

    always_ff @(posedge aclk) begin
        if (en.prod_en) begin
            n_reg <= gm[13:6];
        end
    end

    assign n = n_reg;

endmodule

[rtl/core/simplex_noise_2d_8bit_core.sv]
// ----------------------------------------------------------------------------
// simplex_noise_2d_8bit_core: tiling 2-D simplex noise, one sample per cycle
// while m_tready is high. Each transfer on the s_ side carries one point
// (x, y) in 8.8 unsigned fixed point; bit 15 of each coordinate is ignored,
// so the pattern tiles every 128 units. Each point gives exactly one m_
// transfer holding a signed 1.7 noise value. The core keeps no state between
// points. It is a seven-stage pipeline: one transfer is accepted per cycle
// while m_tready is high, and m_tvalid for a point rises as its result loads
// into the output register. Every stage has its own valid bit and loads
// whenever it is empty or the stage after it moves, so back-pressure on m_
// only halts the stages that hold data and bubbles are squeezed out while
// the output waits.
// ----------------------------------------------------------------------------
module simplex_noise_2d_8bit_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] x_coord, [31:16] y_coord
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata     // [7:0] noise_value (signed)
);

    localparam int NS = sn2_pkg::NUM_STAGES;

    // Pipeline control: valid bit and load enable per stage
    logic [NS:1]   valid_reg;
    logic [NS+1:1] stage_en;

    // Input fields, top bit dropped
    logic [14:0] x, y;

    // Stage 1: skew to the staggered grid and pick the three corners
    logic [15:0] u;
    logic [7:0]  u0, uf0, v0, vf0, xh, yh;
    logic [7:0]  x0, x1, x2, v1, v2;
    logic        upper;
    logic [7:0]        xc_next [3];
    logic [7:0]        vc_next [3];
    logic signed [7:0] xf_next [3];
    logic signed [7:0] yf_next [3];
    logic [7:0]        xc_reg  [3];
    logic [7:0]        vc_reg  [3];
    logic signed [7:0] xf_reg  [3];
    logic signed [7:0] yf_reg  [3];

    // Corner slices (stages 2 to 6)
    sn2_pkg::corner_en_t corner_en;
    logic signed [7:0]   n_corner [3];

    // Stage 7: sum, scale, output register
    logic signed [9:0]  n_sum;
    logic signed [17:0] n_scaled;
    logic [7:0]         result_reg;

    // A stage loads when it is empty or its contents move on this cycle
    always_comb begin
        stage_en[NS+1] = m_tready;
        for (int k = NS; k >= 1; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign s_tready = stage_en[1];

    // Advance valid bits alongside the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[1]) begin
                valid_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Skew: u = x + y[8:1], grid cell from the high bytes, offsets from the low
    always_comb begin
        x   = s_tdata[14:0];
        y   = s_tdata[30:16];
        u   = {1'b0, x} + {8'd0, y[8:1]};
        u0  = u[15:8];
        uf0 = u[7:0];
        v0  = {1'b0, y[14:8]};
        vf0 = y[7:0];
        xh  = x[8:1];
        yh  = y[8:1];

        // odd rows shift left by half a cell
        x0    = {u0[6:0], 1'b0} - {7'd0, y[8]};
        upper = uf0 > vf0;
        v2    = v0 + 8'd1;
        x2    = x0 + 8'd1;
        if (upper) begin
            v1 = v0;
            x1 = x0 + 8'd2;
        end else begin
            v1 = v2;
            x1 = x0 - 8'd1;
        end

        xc_next[0] = x0;
        xc_next[1] = x1;
        xc_next[2] = x2;
        vc_next[0] = v0;
        vc_next[1] = v1;
        vc_next[2] = v2;
        xf_next[0] = xh - {x0[1:0], 6'd0};
        yf_next[0] = {1'b0, y[7:1]};
        xf_next[1] = xh - {x1[1:0], 6'd0};
        yf_next[1] = yh - {v1[0], 7'd0};
        xf_next[2] = xf_next[0] - 8'sd64;
        // offset of a value below 128 minus 128: set the sign bit
        yf_next[2] = {1'b1, y[7:1]};
    end

    // Hold corner data while stage 1 is stalled
    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            for (int c = 0; c < 3; c++) begin
                xc_reg[c] <= xc_next[c];
                vc_reg[c] <= vc_next[c];
                xf_reg[c] <= xf_next[c];
                yf_reg[c] <= yf_next[c];
            end
        end
    end

    assign corner_en = '{
        hash_en: stage_en[2],
        mix_en:  stage_en[3],
        grad_en: stage_en[4],
        fall_en: stage_en[5],
        prod_en: stage_en[6]
    };

    for (genvar c = 0; c < 3; c++) begin : g_corner
        sn2_corner u_corner (
            .aclk (aclk),
            .en   (corner_en),
            .xc   (xc_reg[c]),
            .vc   (vc_reg[c]),
            .xf   (xf_reg[c]),
            .yf   (yf_reg[c]),
            .n    (n_corner[c])
        );
    end

    // Sum the three contributions and scale by 136/128
    always_comb begin
        n_sum    = 10'(n_corner[0]) + 10'(n_corner[1]) + 10'(n_corner[2]);
        n_scaled = n_sum * sn2_pkg::OUT_SCALE;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[NS]) begin
            result_reg <= n_scaled[14:7];
        end
    end

    assign m_tvalid = valid_reg[NS];
    assign m_tdata  = result_reg;

endmodule

[rtl/core/sn2_checker.sv]
// ----------------------------------------------------------------------------
// sn2_checker: port-level checks for the simplex noise core
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module sn2_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    logic s_idle;

    // No input transfer and the output side draining
    assign s_idle = !(s_tvalid && s_tready) && m_tready;

    // A waiting result holds until transferred
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A draining output never blocks the input side
    a_full_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // Draining with no input until every stage flushes leaves nothing to deliver
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_idle ##1 s_idle ##1 s_idle ##1 s_idle ##1 s_idle ##1 s_idle ##1 s_idle
        |=> !m_tvalid)
        else $error("result without a matching input transfer");

endmodule

bind simplex_noise_2d_8bit_core sn2_checker u_sn2_checker (.*);
